// File: rtl/core/plee_pkg.sv
// Package for the positional list engine: field widths, opcodes, status codes
// and default sizes. No dependencies.
package plee_pkg;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned PosWidth    = 7;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 7;

  localparam int unsigned DefaultDepth     = 64;
  localparam int unsigned DefaultElemWidth = 32;

  localparam logic [OpWidth-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [OpWidth-1:0] OP_ADD_REAR  = 3'd1;
  localparam logic [OpWidth-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OpWidth-1:0] OP_DEL_REAR  = 3'd3;
  localparam logic [OpWidth-1:0] OP_INSERT    = 3'd4;
  localparam logic [OpWidth-1:0] OP_DEL_POS   = 3'd5;

  localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
  localparam logic [StatusWidth-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [StatusWidth-1:0] ST_RANGE     = 2'd2;
  localparam logic [StatusWidth-1:0] ST_FULL      = 2'd3;

endpackage

// File: rtl/core/plee_if.sv
// Request and result channels of the positional list engine (valid/ready).
// Depends on plee_pkg for field widths.
interface plee_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [plee_pkg::OpWidth-1:0]   opcode;
  logic        [plee_pkg::PosWidth-1:0]  position;
  logic signed [plee_pkg::ValueWidth-1:0] new_value;

  modport source (output valid, output opcode, output position, output new_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input new_value,
                  output ready);
endinterface

interface plee_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic        [plee_pkg::StatusWidth-1:0]  status;
  logic signed [plee_pkg::ValueWidth-1:0]   removed_value;
  logic        [plee_pkg::CountWidth-1:0]   element_count;
  logic                                     is_empty;

  modport source (output valid, output status, output removed_value,
                  output element_count, output is_empty, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input element_count, input is_empty, output ready);
endinterface

// File: rtl/core/plee_ram.sv
// Element store: single write port, single read port, registered read data.
// No dependencies.
module plee_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/positional_list_engine_unit.sv
// Positional list engine: ordered list of up to DEPTH elements in a circular store.
// Adds at either end and errors go from the request straight to the completion state;
// removals at either end first capture the removed element; a middle insert or delete moves
// one entry per cycle. Next request is taken once the result is loaded.
// Asynchronous reset empties the list at once; the store itself is not cleared.
// Depends on plee_pkg, plee_if and plee_ram.
module positional_list_engine_unit #(
  parameter int unsigned DEPTH      = plee_pkg::DefaultDepth,
  parameter int unsigned ELEM_WIDTH = plee_pkg::DefaultElemWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plee_req_if.sink    req_i,
  plee_rsp_if.source  rsp_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > plee_pkg::PosWidth) ? CW : plee_pkg::PosWidth) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CAP   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(idx);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  logic [1:0]                         state_q, state_d;
  logic [AW-1:0]                      head_q, head_d;
  logic [CW-1:0]                      count_q, count_d;
  logic [CW-1:0]                      k_q, k_d;
  logic [CW-1:0]                      j_q, j_d;
  logic                               dir_q, dir_d;
  logic                               pend_q, pend_d;
  logic [AW-1:0]                      paddr_q, paddr_d;
  logic [ELEM_WIDTH-1:0]              val_q, val_d;
  logic [plee_pkg::StatusWidth-1:0]   status_q, status_d;
  logic [plee_pkg::ValueWidth-1:0]    removed_q, removed_d;
  logic                               out_valid_q;
  logic [plee_pkg::StatusWidth-1:0]   out_status_q;
  logic [plee_pkg::ValueWidth-1:0]    out_removed_q;
  logic [plee_pkg::CountWidth-1:0]    out_count_q;
  logic                               out_empty_q;
  logic                               load;

  logic [plee_pkg::StatusWidth-1:0]   dec_status;
  logic                               dec_ins;
  logic                               dec_del;
  logic [CW-1:0]                      dec_k;
  logic [CMPW-1:0]                    pos_w;
  logic [CMPW-1:0]                    cnt_w;
  logic                               full;
  logic                               empty;

  logic [CW-1:0]                      ridx;
  logic [CW-1:0]                      widx;
  logic [AW-1:0]                      slot_r;
  logic [AW-1:0]                      slot_w;
  logic [AW-1:0]                      slot_j;
  logic [AW-1:0]                      head_m1;
  logic [AW-1:0]                      head_p1;

  logic                               we;
  logic [AW-1:0]                      waddr;
  logic [ELEM_WIDTH-1:0]              wdata;
  logic [ELEM_WIDTH-1:0]              rdata;
  logic [ELEM_WIDTH-1:0]              req_val;

  plee_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (slot_r),
    .rdata_o (rdata)
  );

  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign pos_w   = CMPW'(req_i.position);
  assign cnt_w   = CMPW'(count_q);
  assign req_val = ELEM_WIDTH'($unsigned(req_i.new_value));
  assign head_m1 = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_p1 = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  // request decode
  always_comb begin
    dec_status = plee_pkg::ST_OK;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_k      = '0;
    unique case (req_i.opcode)
      plee_pkg::OP_ADD_FRONT: begin
        if (full) begin
          dec_status = plee_pkg::ST_FULL;
        end else begin
          dec_ins = 1'b1;
        end
      end
      plee_pkg::OP_ADD_REAR: begin
        dec_k = count_q;
        if (full) begin
          dec_status = plee_pkg::ST_FULL;
        end else begin
          dec_ins = 1'b1;
        end
      end
      plee_pkg::OP_DEL_FRONT: begin
        if (empty) begin
          dec_status = plee_pkg::ST_UNDERFLOW;
        end else begin
          dec_del = 1'b1;
        end
      end
      plee_pkg::OP_DEL_REAR: begin
        dec_k = count_q - CW'(1);
        if (empty) begin
          dec_status = plee_pkg::ST_UNDERFLOW;
        end else begin
          dec_del = 1'b1;
        end
      end
      plee_pkg::OP_INSERT: begin
        dec_k = CW'(pos_w - CMPW'(1));
        if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
          dec_status = plee_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = plee_pkg::ST_FULL;
        end else begin
          dec_ins = 1'b1;
        end
      end
      plee_pkg::OP_DEL_POS: begin
        dec_k = CW'(pos_w - CMPW'(1));
        if (pos_w == '0 || pos_w > cnt_w) begin
          dec_status = plee_pkg::ST_RANGE;
        end else begin
          dec_del = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_q == S_SHIFT) begin
      ridx = dir_q ? j_q - CW'(1) : j_q + CW'(1);
      widx = k_q;
    end else begin
      ridx = dec_k;
      widx = dec_k;
    end
  end

  assign slot_r = slot_of(head_q, ridx);
  assign slot_w = slot_of(head_q, widx);
  assign slot_j = slot_of(head_q, j_q);

  assign load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    k_d       = k_q;
    j_d       = j_q;
    dir_d     = dir_q;
    pend_d    = 1'b0;
    paddr_d   = paddr_q;
    val_d     = val_q;
    status_d  = status_q;
    removed_d = removed_q;
    we        = 1'b0;
    waddr     = slot_w;
    wdata     = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          status_d  = dec_status;
          removed_d = '0;
          val_d     = req_val;
          k_d       = dec_k;
          if (dec_ins) begin
            if (dec_k == '0) begin
              we      = 1'b1;
              waddr   = head_m1;
              wdata   = req_val;
              head_d  = head_m1;
              count_d = count_q + CW'(1);
              state_d = S_DONE;
            end else if (dec_k == count_q) begin
              we      = 1'b1;
              wdata   = req_val;
              count_d = count_q + CW'(1);
              state_d = S_DONE;
            end else begin
              j_d     = count_q;
              dir_d   = 1'b1;
              state_d = S_SHIFT;
            end
          end else if (dec_del) begin
            state_d = S_CAP;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CAP: begin
        removed_d = plee_pkg::ValueWidth'(rdata);
        if (k_q == '0) begin
          count_d = count_q - CW'(1);
          head_d  = (count_q == CW'(1)) ? '0 : head_p1;
          state_d = S_DONE;
        end else if (k_q == count_q - CW'(1)) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          j_d     = k_q;
          dir_d   = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = paddr_q;
          wdata = rdata;
        end
        if (dir_q) begin
          if (j_q > k_q) begin
            pend_d  = 1'b1;
            paddr_d = slot_j;
            j_d     = j_q - CW'(1);
          end else if (!pend_q) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
            state_d = S_DONE;
          end
        end else begin
          if ((CW+1)'(j_q) + (CW+1)'(1) < (CW+1)'(count_q)) begin
            pend_d  = 1'b1;
            paddr_d = slot_j;
            j_d     = j_q + CW'(1);
          end else if (!pend_q) begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    j_q       <= j_d;
    dir_q     <= dir_d;
    paddr_q   <= paddr_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q  <= status_q;
      out_removed_q <= removed_q;
      out_count_q   <= plee_pkg::CountWidth'(count_q);
      out_empty_q   <= (count_q == '0);
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.element_count = out_count_q;
  assign rsp_o.is_empty      = out_empty_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending move while idle");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + CW'(1) ||
                           count_q + CW'(1) == $past(count_q)))
    else $error("element count moved by more than one");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("empty list with head away from slot zero");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (count_q < CW'(DEPTH) || !dir_q))
    else $error("insert shift on a full list");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside completion");

endmodule
